// File: rtl/core/ole_pkg.sv
`default_nettype none

package ole_pkg;

    // Entry storage
    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;

    // Port field widths
    localparam int REQ_W = 3;
    localparam int POS_W = 8;
    localparam int RES_W = 11;

    // Width for position and count arithmetic (count up to 1024, plus one)
    localparam int CALC_W = 12;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FIRST = 3'd0,
        REQ_INS_LAST  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FIRST = 3'd3,
        REQ_DEL_LAST  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_COUNT     = 3'd6,
        REQ_SEARCH    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Kind of walk the sequencer runs over the entries
    typedef enum logic [2:0] {
        MODE_INS  = 3'b001,
        MODE_DEL  = 3'b010,
        MODE_SRCH = 3'b100
    } mode_t;

endpackage : ole_pkg

`default_nettype wire

// File: rtl/core/ordered_list_engine.sv
`default_nettype none

// Ordered list engine: holds up to DEPTH signed 32-bit values in order and
// serves insert, delete, count and search requests, one at a time. Raise
// start with the request fields while busy is low; the request is taken at
// that edge, and busy is high while it walks or writes the entries. Every
// request gives exactly one result beat: done is high for a single cycle
// with status, found, found_position and entry_count valid. The receiver
// cannot stall, so capture the result in the cycle done is high. Count,
// delete last, delete at the last position, search on an empty list and
// every request rejected with a status code answer in the cycle after
// start. The entries live in a single-port-write, registered-read memory,
// and one sequencer walks it one entry per cycle. With L the entry count,
// insert at 1-based position p <= L moves entries p..L up by one, then
// writes the value (an append, p = L+1, writes it at once); delete at
// position p < L moves entries p+1..L down by one (delete first is p = 1);
// a search stops at a hit or after position L. Insert at a valid position
// into a full list reports list full and drops the value; delete first or
// last on an empty list reports list empty.
module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic        [ole_pkg::REQ_W-1:0]   req_type,
    input  wire logic signed [ole_pkg::DATA_W-1:0]  value,
    input  wire logic        [ole_pkg::POS_W-1:0]   position,
    output logic                                    done,
    output logic             [1:0]                  status,
    output logic                                    found,
    output logic             [ole_pkg::RES_W-1:0]   found_position,
    output logic             [ole_pkg::RES_W-1:0]   entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ole_pkg::CALC_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    // Sequencer state
    state_t                     state_reg,    state_next;
    ole_pkg::mode_t             mode_reg,     mode_next;
    logic [CW-1:0]              len_reg,      len_next;
    logic [CW-1:0]              left_reg,     left_next;
    logic [AW-1:0]              rd_addr_reg,  rd_addr_next;
    logic                       pend_reg,     pend_next;
    logic [AW-1:0]              pend_addr_reg, pend_addr_next;
    logic [AW-1:0]              idx_reg,      idx_next;
    logic [ole_pkg::DATA_W-1:0] value_reg,    value_next;

    // Result beat
    logic                       done_reg,     done_next;
    logic [1:0]                 status_reg,   status_next;
    logic                       found_reg,    found_next;
    logic [ole_pkg::RES_W-1:0]  fpos_reg,     fpos_next;

    // Memory port
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [ole_pkg::DATA_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ole_pkg::DATA_W-1:0] mem_rdata;

    // Shared step unit: address advance, write-back target, compare
    logic [AW-1:0]              step_addr;
    logic [AW-1:0]              dst_addr;
    logic                       hit;
    logic [ole_pkg::RES_W-1:0]  hit_pos;

    // Request decode
    logic [XW-1:0]              len_x;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              ins_pos_x;
    logic [XW-1:0]              ins_idx_x;
    logic [XW-1:0]              del_idx_x;
    logic [XW-1:0]              ins_cnt_x;
    logic [XW-1:0]              del_cnt_x;
    logic                       run_issue;
    logic                       srch_hit;

    ole_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    // Inserts walk down from the tail, deletes and searches walk up.
    assign step_addr = (mode_reg == ole_pkg::MODE_INS) ? rd_addr_reg - AW'(1)
                                                       : rd_addr_reg + AW'(1);
    assign dst_addr  = (mode_reg == ole_pkg::MODE_INS) ? pend_addr_reg + AW'(1)
                                                       : pend_addr_reg - AW'(1);
    assign hit       = (mem_rdata == value_reg);
    assign hit_pos   = ole_pkg::RES_W'(pend_addr_reg) + ole_pkg::RES_W'(1);

    assign len_x     = XW'(len_reg);
    assign pos_x     = XW'(position);
    assign ins_pos_x = (req_type == ole_pkg::REQ_INS_FIRST) ? XW'(1)
                     : (req_type == ole_pkg::REQ_INS_LAST)  ? len_x + XW'(1)
                     : pos_x;
    assign ins_idx_x = ins_pos_x - XW'(1);
    assign del_idx_x = (req_type == ole_pkg::REQ_DEL_FIRST) ? XW'(0) : pos_x - XW'(1);
    assign ins_cnt_x = len_x - ins_idx_x;
    assign del_cnt_x = len_x - XW'(1) - del_idx_x;

    assign srch_hit  = (mode_reg == ole_pkg::MODE_SRCH) && pend_reg && hit;
    assign run_issue = (left_reg != '0) && !srch_hit;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        done_next      = 1'b0;
        status_next    = ole_pkg::ST_OK;
        found_next     = 1'b0;
        fpos_next      = '0;
        mem_we         = 1'b0;
        mem_waddr      = dst_addr;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    case (req_type)
                        ole_pkg::REQ_INS_FIRST,
                        ole_pkg::REQ_INS_LAST,
                        ole_pkg::REQ_INS_POS:
                        begin
                            mode_next = ole_pkg::MODE_INS;
                            idx_next  = AW'(ins_idx_x);
                            if (ins_pos_x == '0 || ins_pos_x > len_x + XW'(1))
                            begin
                                done_next   = 1'b1;
                                status_next = ole_pkg::ST_BADPOS;
                            end
                            else if (len_x >= XW'(DEPTH))
                            begin
                                done_next   = 1'b1;
                                status_next = ole_pkg::ST_FULL;
                            end
                            else if (ins_cnt_x == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                // Open a gap: move entries idx..L-1 up by one.
                                state_next   = S_RUN;
                                rd_addr_next = AW'(len_x - XW'(1));
                                left_next    = CW'(ins_cnt_x);
                            end
                        end
                        ole_pkg::REQ_DEL_LAST:
                        begin
                            done_next = 1'b1;
                            if (len_reg == '0)
                            begin
                                status_next = ole_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                len_next = len_reg - CW'(1);
                            end
                        end
                        ole_pkg::REQ_DEL_FIRST,
                        ole_pkg::REQ_DEL_POS:
                        begin
                            mode_next = ole_pkg::MODE_DEL;
                            if (req_type == ole_pkg::REQ_DEL_FIRST && len_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ole_pkg::ST_EMPTY;
                            end
                            else if (req_type == ole_pkg::REQ_DEL_POS &&
                                     (pos_x == '0 || pos_x > len_x))
                            begin
                                done_next   = 1'b1;
                                status_next = ole_pkg::ST_BADPOS;
                            end
                            else if (del_cnt_x == '0)
                            begin
                                done_next = 1'b1;
                                len_next  = len_reg - CW'(1);
                            end
                            else
                            begin
                                // Close the gap: move entries idx+1..L-1 down by one.
                                state_next   = S_RUN;
                                rd_addr_next = AW'(del_idx_x + XW'(1));
                                left_next    = CW'(del_cnt_x);
                            end
                        end
                        ole_pkg::REQ_COUNT:
                        begin
                            done_next = 1'b1;
                        end
                        ole_pkg::REQ_SEARCH:
                        begin
                            mode_next = ole_pkg::MODE_SRCH;
                            if (len_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next   = S_RUN;
                                rd_addr_next = '0;
                                left_next    = len_reg;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // Retire the entry read last cycle.
                if (pend_reg)
                begin
                    if (mode_reg == ole_pkg::MODE_SRCH)
                    begin
                        if (hit)
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b1;
                            fpos_next  = hit_pos;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end

                // Issue the next read.
                if (run_issue)
                begin
                    mem_re         = 1'b1;
                    rd_addr_next   = step_addr;
                    left_next      = left_reg - CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                end

                // Walk finished with the last entry retired.
                if (left_reg == '0 && pend_reg && !srch_hit)
                begin
                    case (mode_reg)
                        ole_pkg::MODE_INS:
                        begin
                            state_next = S_FIN;
                        end
                        ole_pkg::MODE_DEL:
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                            len_next   = len_reg - CW'(1);
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                // Drop the new value into the opened slot.
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = value_reg;
                len_next   = len_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload and walk bookkeeping: no reset needed.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        left_reg      <= left_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        idx_reg       <= idx_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        fpos_reg      <= fpos_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign entry_count    = ole_pkg::RES_W'(len_reg);

endmodule : ordered_list_engine

`default_nettype wire

// File: rtl/core/ole_mem.sv
`default_nettype none

// Entry store: one write port, one read port with registered read data.
module ole_mem #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(ole_pkg::DEPTH_DEFAULT)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [ole_pkg::DATA_W-1:0]  wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [ole_pkg::DATA_W-1:0]  rdata
);

    logic [ole_pkg::DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule : ole_mem

`default_nettype wire
